// ----- rtl/aeba_pkg.sv -----
// shared constants, codes and helpers of the extent block allocator
package aeba_pkg;

    localparam int DEF_MAX_EXTENTS = 64;
    localparam int DEF_BLOCK_BITS  = 32;
    localparam int SZW             = 19;
    localparam int REG_W           = 32;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 72;
    localparam int PADDR_W         = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] REG_FIRST = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_USED  = 2'd2;

    localparam logic [1:0] BT_ONE   = 2'd0;
    localparam logic [1:0] BT_512   = 2'd1;
    localparam logic [1:0] BT_256K  = 2'd2;

    typedef struct packed {
        logic skip;
        logic left;
        logic right;
    } t_eval;

    function automatic logic [SZW-1:0] size_of(input logic [1:0] bt);
        logic [SZW-1:0] r;
        case (bt)
            BT_ONE:  r = SZW'(1);
            BT_512:  r = SZW'(512);
            BT_256K: r = SZW'(262144);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/aeba_mem.sv -----
// extent table memory, one write port and one registered read port
module aeba_mem import aeba_pkg::*; #(
    parameter int DEPTH = DEF_MAX_EXTENTS,
    parameter int W     = DEF_BLOCK_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wlo,
    input  logic [W-1:0]             i_whi,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rlo,
    output logic [W-1:0]             o_rhi
);

    logic [W-1:0] r_lo [DEPTH];
    logic [W-1:0] r_hi [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_lo[i_waddr] <= i_wlo;
            r_hi[i_waddr] <= i_whi;
        end
        o_rlo <= r_lo[i_raddr];
        o_rhi <= r_hi[i_raddr];
    end

endmodule

// ----- rtl/aeba_unit.sv -----
// shared candidate placement and range compare unit
module aeba_unit import aeba_pkg::*; #(
    parameter int W = DEF_BLOCK_BITS + 1
) (
    input  logic           i_free,
    input  logic [SZW-1:0] i_n,
    input  logic [W-1:0]   i_lo,
    input  logic [W-1:0]   i_hi,
    input  logic [W-1:0]   i_next_low,
    input  logic           i_has_next,
    input  logic [W-1:0]   i_bn,
    input  logic [W-1:0]   i_bmask,
    output t_eval          o_eval,
    output logic [W-1:0]   o_nl,
    output logic [W-1:0]   o_nh
);

    logic [W-1:0] n_w;
    logic [W-1:0] base;

    always_comb begin
        n_w  = W'(i_n);
        base = i_free ? i_bn : ((i_hi + n_w) & ~(n_w - W'(1)));
        o_nl = base;
        o_nh = base + n_w - W'(1);
        if (i_free) begin
            o_eval.skip  = (base > i_hi) || (base < i_lo) || (o_nh > i_hi);
            o_eval.left  = (base == i_lo);
            o_eval.right = (o_nh == i_hi);
        end else begin
            o_eval.skip  = (o_nh >= i_next_low) || (o_nh > i_bmask);
            o_eval.left  = (base == i_hi + W'(1));
            o_eval.right = i_has_next && (o_nh + W'(1) == i_next_low);
        end
    end

endmodule

// ----- rtl/aligned_extent_block_allocator.sv -----
// top level: sequencer walking the extent table through the shared unit
// allocate walks the extent table through S_ALOAD and S_ASTEP, free through S_FSTEP;
// an unknown size class or an empty table is answered straight from S_IDLE;
// table entries are moved in S_SHIFT on insert or delete, and S_FINAL writes a pending new entry
// throughput: one item at a time, bounded by the one-entry-per-cycle table port
// reset and every register write pass through S_INIT, which sets up the table entry 0
module aligned_extent_block_allocator import aeba_pkg::*; #(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int BLOCK_BITS  = DEF_BLOCK_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // cmd, block_type, block_number
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status, allocated_block, free_count
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [REG_W-1:0]       pwdata,
    output logic [REG_W-1:0]       prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int W  = BLOCK_BITS + 1;
    localparam int SW = ((W > 33) ? W : 33) + 1;
    localparam logic [W-1:0]  BMASK = {1'b0, {BLOCK_BITS{1'b1}}};
    localparam logic [CW:0]   CMAX  = (CW + 1)'(MAX_EXTENTS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ALOAD = 3'd2;
    localparam logic [2:0] S_ASTEP = 3'd3;
    localparam logic [2:0] S_FSTEP = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [REG_W-1:0] r_first, n_first, r_end, n_end, r_used, n_used;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_free, n_free;
    logic [AW-1:0]    r_idx, n_idx;
    logic [W-1:0]     r_cur_lo, n_cur_lo, r_cur_hi, n_cur_hi;
    logic             r_cmd, n_cmd;
    logic [SZW-1:0]   r_n, n_n;
    logic [W-1:0]     r_bn, n_bn;
    logic [AW-1:0]    r_sj, n_sj, r_slast, n_slast;
    logic             r_sup, n_sup, r_fin_pend, n_fin_pend;
    logic [AW-1:0]    r_fin_addr, n_fin_addr;
    logic [W-1:0]     r_fin_lo, n_fin_lo, r_fin_hi, n_fin_hi;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_alloc, n_alloc;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [W-1:0]     mem_wlo, mem_whi, rd_lo, rd_hi;

    logic             cfg_wr, cfg_hit;
    logic [1:0]       cfg_idx;
    logic             in_acc;

    logic [W+31:0]    first_x, end_x, bn_x;
    logic [W-1:0]     lo0, hi0, lim, bn_in;
    logic [31:0]      used1, free0;
    logic [SW-1:0]    hi0_s;

    logic [CW:0]      i_c, cnt_c;
    logic             has_next;
    logic [W-1:0]     u_lo, u_hi, u_next;
    t_eval            ev;
    logic [W-1:0]     nl, nh;
    logic [W+31:0]    nl_x;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (cfg_idx == REG_FIRST || cfg_idx == REG_END ||
                                cfg_idx == REG_USED);

    always_comb begin
        case (cfg_idx)
            REG_FIRST: prdata = r_first;
            REG_END:   prdata = r_end;
            REG_USED:  prdata = r_used;
            default:   prdata = '0;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready) && !cfg_wr;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'b0, r_free, r_alloc, r_status};

    always_comb begin
        first_x = {{W{1'b0}}, r_first};
        end_x   = {{W{1'b0}}, r_end};
        bn_x    = {{W{1'b0}}, i_s_axis_tdata[34:3]};
        lo0     = first_x[W-1:0] & BMASK;
        lim     = end_x[W-1:0] & BMASK;
        bn_in   = bn_x[W-1:0] & BMASK;
        used1   = (r_used == '0) ? 32'd1 : r_used;
        hi0_s   = SW'(lo0) + SW'(used1) - SW'(1);
        hi0     = (hi0_s > SW'(BMASK)) ? BMASK : hi0_s[W-1:0];
        free0   = r_end - r_first - used1;
    end

    assign i_c      = (CW + 1)'(r_idx);
    assign cnt_c    = (CW + 1)'(r_count);
    assign has_next = (i_c + (CW + 1)'(1)) < cnt_c;
    assign u_lo     = rd_lo;
    assign u_hi     = r_cmd ? rd_hi : r_cur_hi;
    assign u_next   = has_next ? rd_lo : lim;
    assign nl_x     = {32'b0, nl};

    aeba_mem #(.DEPTH(MAX_EXTENTS), .W(W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wlo   (mem_wlo),
        .i_whi   (mem_whi),
        .i_raddr (mem_raddr),
        .o_rlo   (rd_lo),
        .o_rhi   (rd_hi)
    );

    aeba_unit #(.W(W)) u_unit (
        .i_free     (r_cmd),
        .i_n        (r_n),
        .i_lo       (u_lo),
        .i_hi       (u_hi),
        .i_next_low (u_next),
        .i_has_next (has_next),
        .i_bn       (r_bn),
        .i_bmask    (BMASK),
        .o_eval     (ev),
        .o_nl       (nl),
        .o_nh       (nh)
    );

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_end      = r_end;
        n_used     = r_used;
        n_count    = r_count;
        n_free     = r_free;
        n_idx      = r_idx;
        n_cur_lo   = r_cur_lo;
        n_cur_hi   = r_cur_hi;
        n_cmd      = r_cmd;
        n_n        = r_n;
        n_bn       = r_bn;
        n_sj       = r_sj;
        n_slast    = r_slast;
        n_sup      = r_sup;
        n_fin_pend = r_fin_pend;
        n_fin_addr = r_fin_addr;
        n_fin_lo   = r_fin_lo;
        n_fin_hi   = r_fin_hi;
        n_ovalid   = r_ovalid;
        n_status   = r_status;
        n_alloc    = r_alloc;
        mem_we     = 1'b0;
        mem_waddr  = r_sj;
        mem_wlo    = rd_lo;
        mem_whi    = rd_hi;
        mem_raddr  = '0;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wlo   = lo0;
                mem_whi   = hi0;
                n_count   = CW'(1);
                n_free    = free0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_s_axis_tdata[0];
                    n_n     = size_of(i_s_axis_tdata[2:1]);
                    n_bn    = bn_in;
                    n_idx   = '0;
                    n_alloc = '0;
                    if (size_of(i_s_axis_tdata[2:1]) == '0 || r_count == '0) begin
                        n_status = (i_s_axis_tdata[0] == CMD_FREE) ? ST_NOT_HELD : ST_NO_SPACE;
                        n_ovalid = 1'b1;
                    end else begin
                        n_state = (i_s_axis_tdata[0] == CMD_FREE) ? S_FSTEP : S_ALOAD;
                    end
                end
            end
            S_ALOAD: begin
                n_cur_lo  = rd_lo;
                n_cur_hi  = rd_hi;
                mem_raddr = AW'(1);
                n_state   = S_ASTEP;
            end
            S_ASTEP: begin
                n_status = ST_OK;
                n_alloc  = nl_x[31:0];
                n_free   = r_free - 32'(r_n);
                n_state  = S_IDLE;
                n_ovalid = 1'b1;
                if (ev.skip) begin
                    n_alloc = '0;
                    n_free  = r_free;
                    if (has_next) begin
                        n_cur_lo  = rd_lo;
                        n_cur_hi  = rd_hi;
                        n_idx     = r_idx + AW'(1);
                        mem_raddr = AW'(i_c + (CW + 1)'(2));
                        n_state   = S_ASTEP;
                        n_ovalid  = r_ovalid;
                    end else begin
                        n_status = ST_NO_SPACE;
                    end
                end else if (ev.left && ev.right) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wlo   = r_cur_lo;
                    mem_whi   = rd_hi;
                    n_count   = r_count - CW'(1);
                    if (i_c + (CW + 1)'(3) <= cnt_c) begin
                        n_sup      = 1'b0;
                        n_fin_pend = 1'b0;
                        n_sj       = AW'(i_c + (CW + 1)'(1));
                        n_slast    = AW'(cnt_c - (CW + 1)'(2));
                        mem_raddr  = AW'(i_c + (CW + 1)'(2));
                        n_state    = S_SHIFT;
                        n_ovalid   = 1'b0;
                    end
                end else if (ev.left) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wlo   = r_cur_lo;
                    mem_whi   = nh;
                end else if (ev.right) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(i_c + (CW + 1)'(1));
                    mem_wlo   = nl;
                    mem_whi   = rd_hi;
                end else if (cnt_c >= CMAX) begin
                    n_status = ST_FULL;
                    n_alloc  = '0;
                    n_free   = r_free;
                end else begin
                    n_count = r_count + CW'(1);
                    if (has_next) begin
                        n_fin_pend = 1'b1;
                        n_fin_addr = AW'(i_c + (CW + 1)'(1));
                        n_fin_lo   = nl;
                        n_fin_hi   = nh;
                        n_sup      = 1'b1;
                        n_sj       = AW'(cnt_c);
                        n_slast    = AW'(i_c + (CW + 1)'(2));
                        mem_raddr  = AW'(cnt_c - (CW + 1)'(1));
                        n_state    = S_SHIFT;
                        n_ovalid   = 1'b0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(i_c + (CW + 1)'(1));
                        mem_wlo   = nl;
                        mem_whi   = nh;
                    end
                end
            end
            S_FSTEP: begin
                n_status = ST_OK;
                n_alloc  = '0;
                n_free   = r_free + 32'(r_n);
                n_state  = S_IDLE;
                n_ovalid = 1'b1;
                if (ev.skip) begin
                    n_free = r_free;
                    if (has_next) begin
                        n_idx     = r_idx + AW'(1);
                        mem_raddr = AW'(i_c + (CW + 1)'(1));
                        n_state   = S_FSTEP;
                        n_ovalid  = r_ovalid;
                    end else begin
                        n_status = ST_NOT_HELD;
                    end
                end else if (ev.left && ev.right) begin
                    n_count = r_count - CW'(1);
                    if (i_c + (CW + 1)'(2) <= cnt_c) begin
                        n_sup      = 1'b0;
                        n_fin_pend = 1'b0;
                        n_sj       = r_idx;
                        n_slast    = AW'(cnt_c - (CW + 1)'(2));
                        mem_raddr  = AW'(i_c + (CW + 1)'(1));
                        n_state    = S_SHIFT;
                        n_ovalid   = 1'b0;
                    end
                end else if (ev.left) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wlo   = nh + W'(1);
                    mem_whi   = rd_hi;
                end else if (ev.right) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wlo   = rd_lo;
                    mem_whi   = nl - W'(1);
                end else if (cnt_c >= CMAX) begin
                    n_status = ST_FULL;
                    n_free   = r_free;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_idx;
                    mem_wlo    = rd_lo;
                    mem_whi    = nl - W'(1);
                    n_count    = r_count + CW'(1);
                    n_fin_pend = 1'b1;
                    n_fin_addr = AW'(i_c + (CW + 1)'(1));
                    n_fin_lo   = nh + W'(1);
                    n_fin_hi   = rd_hi;
                    n_ovalid   = 1'b0;
                    if (has_next) begin
                        n_sup     = 1'b1;
                        n_sj      = AW'(cnt_c);
                        n_slast   = AW'(i_c + (CW + 1)'(2));
                        mem_raddr = AW'(cnt_c - (CW + 1)'(1));
                        n_state   = S_SHIFT;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_sj;
                if (r_sj == r_slast) begin
                    if (r_fin_pend) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state  = S_IDLE;
                        n_ovalid = 1'b1;
                    end
                end else if (r_sup) begin
                    n_sj      = r_sj - AW'(1);
                    mem_raddr = r_sj - AW'(2);
                end else begin
                    n_sj      = r_sj + AW'(1);
                    mem_raddr = r_sj + AW'(2);
                end
            end
            S_FINAL: begin
                mem_we     = 1'b1;
                mem_waddr  = r_fin_addr;
                mem_wlo    = r_fin_lo;
                mem_whi    = r_fin_hi;
                n_fin_pend = 1'b0;
                n_state    = S_IDLE;
                n_ovalid   = 1'b1;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (cfg_hit) begin
            case (cfg_idx)
                REG_FIRST: n_first = pwdata;
                REG_END:   n_end   = pwdata;
                REG_USED:  n_used  = pwdata;
                default:   n_first = r_first;
            endcase
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_first    <= '0;
            r_end      <= '1;
            r_used     <= 32'd1;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_fin_pend <= 1'b0;
            r_idx      <= '0;
            r_sj       <= '0;
            r_slast    <= '0;
            r_sup      <= 1'b0;
            r_cmd      <= CMD_ALLOC;
        end else begin
            r_state    <= n_state;
            r_first    <= n_first;
            r_end      <= n_end;
            r_used     <= n_used;
            r_count    <= n_count;
            r_ovalid   <= n_ovalid;
            r_fin_pend <= n_fin_pend;
            r_idx      <= n_idx;
            r_sj       <= n_sj;
            r_slast    <= n_slast;
            r_sup      <= n_sup;
            r_cmd      <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free     <= n_free;
        r_cur_lo   <= n_cur_lo;
        r_cur_hi   <= n_cur_hi;
        r_n        <= n_n;
        r_bn       <= n_bn;
        r_fin_addr <= n_fin_addr;
        r_fin_lo   <= n_fin_lo;
        r_fin_hi   <= n_fin_hi;
        r_status   <= n_status;
        r_alloc    <= n_alloc;
    end

endmodule

// ----- rtl/aeba_checker.sv -----
// port-level checks of the extent block allocator, bound to the top level
module aeba_checker import aeba_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [PADDR_W-1:0]     paddr,
    input logic [REG_W-1:0]       pwdata,
    input logic [REG_W-1:0]       prdata,
    input logic                   pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid || !o_s_axis_tready)
        else $error("ready without result after item accepted");

    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_OK |-> o_m_axis_tdata[33:2] == '0)
        else $error("block reported on failed request");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !(i_s_axis_tvalid && o_s_axis_tready)
        |=> !o_m_axis_tvalid)
        else $error("result without item");

endmodule

bind aligned_extent_block_allocator aeba_checker u_aeba_checker (.*);
